@@ rtl/iss_pkg.sv @@
// Shared types, codes and sizing constants for the inspect-and-sort sequencer.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package iss_pkg;

    // Verdict store depth and derived widths
    localparam int MAX_CHIPS = 4;
    localparam int CNT_W     = $clog2(MAX_CHIPS + 1);
    localparam int IDX_W     = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

    // Fixed field widths
    localparam int CMD_W     = 3;
    localparam int SLOT_W    = 8;
    localparam int DIST_W    = 15;
    localparam int MM_W      = 12;
    localparam int CPC_W     = 3;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHIPS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIDGE  = 2'd2;

    // Configuration reset values
    localparam logic [CPC_W-1:0] CHIPS_RST   = 3'd4;
    localparam logic [MM_W-1:0]  SPACING_RST = 12'd20;
    localparam logic [MM_W-1:0]  BRIDGE_RST  = 12'd50;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESET     = 3'd0,
        CMD_RESULT    = 3'd1,
        CMD_FWD_DONE  = 3'd2,
        CMD_BACK_DONE = 3'd3,
        CMD_INTERRUPT = 3'd4,
        CMD_SORT_DONE = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_FWD  = 3'd1,
        ACT_BACK = 3'd2,
        ACT_SORT = 3'd3,
        ACT_DONE = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_INSPECT = 3'd1,
        PH_TO_SORT = 3'd2,
        PH_SORTING = 3'd3,
        PH_NEXT    = 3'd4,
        PH_RETURN  = 3'd5,
        PH_DONE    = 3'd6,
        PH_ERROR   = 3'd7
    } t_phase;

    // Effective (clamped) configuration seen by the sequencer
    typedef struct packed {
        logic [CNT_W-1:0]  chips;
        logic [MM_W-1:0]   spacing;
        logic [MM_W-1:0]   bridge;
        logic [DIST_W-1:0] ret_dist;
    } t_cfg_eff;

    // One input word as held in the input register
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot;
        logic              good;
        logic              ok;
    } t_event;

    // One stored inspection verdict
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              good;
    } t_verdict;

    // One result word
    typedef struct packed {
        t_action           action;
        logic [DIST_W-1:0] move_mm;
        logic [SLOT_W-1:0] slot;
        logic              good;
        logic              accepted;
        t_phase            phase;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/iss_cfg_regs.sv @@
// Configuration registers and the clamped values derived from them.
// Depends on iss_pkg.
`default_nettype none

module iss_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [iss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [iss_pkg::CFG_W-1:0]     i_cfg_data,
    output iss_pkg::t_cfg_eff                  o_cfg
);
    import iss_pkg::*;

    localparam int SUM_W = MM_W + CNT_W + 2;

    logic [CPC_W-1:0] r_chips;
    logic [MM_W-1:0]  r_spacing;
    logic [MM_W-1:0]  r_bridge;

    logic [CNT_W-1:0] chips_eff;
    logic [MM_W-1:0]  spacing_eff;
    logic [MM_W-1:0]  bridge_eff;
    logic [CNT_W-1:0] chips_m1;
    logic [SUM_W-1:0] ret_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chips   <= CHIPS_RST;
            r_spacing <= SPACING_RST;
            r_bridge  <= BRIDGE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_CHIPS) begin
                r_chips <= i_cfg_data[CPC_W-1:0];
            end
            if (i_cfg_index == CFG_SPACING) begin
                r_spacing <= i_cfg_data[MM_W-1:0];
            end
            if (i_cfg_index == CFG_BRIDGE) begin
                r_bridge <= i_cfg_data[MM_W-1:0];
            end
        end
    end

    // zero acts as one; chip count above the store depth acts as the depth
    always_comb begin
        if (r_chips == '0) begin
            chips_eff = CNT_W'(1);
        end else if (int'(r_chips) > MAX_CHIPS) begin
            chips_eff = CNT_W'(MAX_CHIPS);
        end else begin
            chips_eff = CNT_W'(r_chips);
        end
    end

    assign spacing_eff = (r_spacing == '0) ? MM_W'(1) : r_spacing;
    assign bridge_eff  = (r_bridge == '0) ? MM_W'(1) : r_bridge;
    assign chips_m1    = chips_eff - CNT_W'(1);

    // return move: 2*(n-1)*spacing + bridge, saturated
    assign ret_sum = SUM_W'({chips_m1, 1'b0}) * SUM_W'(spacing_eff) + SUM_W'(bridge_eff);

    assign o_cfg.chips    = chips_eff;
    assign o_cfg.spacing  = spacing_eff;
    assign o_cfg.bridge   = bridge_eff;
    assign o_cfg.ret_dist = (ret_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : ret_sum[DIST_W-1:0];

endmodule

`default_nettype wire

@@ rtl/iss_seq_core.sv @@
// Sequencer state, verdict store and next-result logic for one event word.
// Depends on iss_pkg.
`default_nettype none

module iss_seq_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire iss_pkg::t_event   i_event,
    input  wire iss_pkg::t_cfg_eff i_cfg,
    output iss_pkg::t_result       o_result
);
    import iss_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_pos,   n_pos;
    t_verdict         r_store [MAX_CHIPS];

    logic             store_we;
    logic [IDX_W-1:0] store_idx;
    t_verdict         rd_verdict;
    logic [CNT_W-1:0] cnt_cur;
    logic [CNT_W-1:0] pos_inc;
    t_phase           ph_cur;
    t_result          res;

    assign rd_verdict = r_store[r_pos[IDX_W-1:0]];
    assign pos_inc    = r_pos + CNT_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_pos     = r_pos;
        store_we  = 1'b0;
        store_idx = r_count[IDX_W-1:0];
        ph_cur    = r_phase;
        cnt_cur   = r_count;
        res       = '0;
        res.action = ACT_NONE;

        if (i_valid) begin
            unique case (t_cmd'(i_event.command))
                CMD_RESET: begin
                    n_count = '0;
                    n_pos   = '0;
                    n_phase = PH_INSPECT;
                end
                CMD_RESULT: begin
                    // a result after idle, complete or error starts a new cycle
                    if (r_phase == PH_IDLE || r_phase == PH_DONE || r_phase == PH_ERROR) begin
                        ph_cur  = PH_INSPECT;
                        cnt_cur = '0;
                        n_pos   = '0;
                    end
                    n_count = cnt_cur;
                    if (ph_cur == PH_INSPECT && int'(cnt_cur) < MAX_CHIPS) begin
                        store_we     = 1'b1;
                        store_idx    = cnt_cur[IDX_W-1:0];
                        n_count      = cnt_cur + CNT_W'(1);
                        res.accepted = 1'b1;
                        if (n_count >= i_cfg.chips) begin
                            n_pos       = '0;
                            res.action  = ACT_FWD;
                            res.move_mm = DIST_W'(i_cfg.bridge);
                            ph_cur      = PH_TO_SORT;
                        end
                    end
                    n_phase = ph_cur;
                end
                CMD_FWD_DONE: begin
                    if (r_phase == PH_TO_SORT || r_phase == PH_NEXT) begin
                        if (r_pos >= r_count) begin
                            n_phase = PH_ERROR;
                        end else begin
                            res.action = ACT_SORT;
                            res.slot   = rd_verdict.slot;
                            res.good   = rd_verdict.good;
                            n_phase    = PH_SORTING;
                        end
                    end
                end
                CMD_BACK_DONE: begin
                    if (r_phase == PH_RETURN) begin
                        res.action = ACT_DONE;
                        n_phase    = PH_DONE;
                    end
                end
                CMD_INTERRUPT: begin
                    n_phase = PH_ERROR;
                end
                CMD_SORT_DONE: begin
                    if (r_phase == PH_SORTING) begin
                        if (!i_event.ok) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_pos = pos_inc;
                            if (pos_inc < r_count) begin
                                res.action  = ACT_FWD;
                                res.move_mm = DIST_W'(i_cfg.spacing);
                                n_phase     = PH_NEXT;
                            end else begin
                                res.action  = ACT_BACK;
                                res.move_mm = i_cfg.ret_dist;
                                n_phase     = PH_RETURN;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        res.phase = n_phase;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_pos   <= n_pos;
        end
    end

    // verdict store: no reset, entries are read only after being written
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_idx] <= {i_event.slot, i_event.good};
        end
    end

endmodule

`default_nettype wire

@@ rtl/inspect_and_sort_sequencer_unit.sv @@
// Inspect-and-sort sequencer top level: input register, sequencer core, result register.
// A taken word passes the input register, the core and the result register to o_valid.
// Throughput: one word per cycle unless busy; one pass of logic between registers.
// Reset (i_rst_n low, synchronous): phase idle, counts cleared, config to 4/20/50,
// o_busy high until the first edge after reset; the receiver cannot stall results.
// Depends on iss_pkg, iss_cfg_regs, iss_seq_core.
`default_nettype none

module inspect_and_sort_sequencer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command channel
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [iss_pkg::CMD_W-1:0]     i_command,
    input  wire logic [iss_pkg::SLOT_W-1:0]    i_slot_number,
    input  wire logic                          i_chip_good,
    input  wire logic                          i_action_ok,
    // result channel
    output logic                               o_valid,
    output logic [2:0]                         o_action,
    output logic [iss_pkg::DIST_W-1:0]         o_move_mm,
    output logic [iss_pkg::SLOT_W-1:0]         o_sort_slot,
    output logic                               o_sort_good,
    output logic                               o_accepted,
    output logic [2:0]                         o_phase,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [iss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [iss_pkg::CFG_W-1:0]     i_cfg_data
);
    import iss_pkg::*;

    logic     r_busy;
    logic     r_in_valid;
    t_event   r_event;
    logic     r_out_valid;
    t_result  r_result;

    t_cfg_eff cfg;
    t_result  core_result;
    logic     take;

    // Busy only right after reset; otherwise a word is taken every cycle that i_start is high.
    assign take = i_start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Input register: valid bit under reset, payload free-running on take.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_event <= {i_command, i_slot_number, i_chip_good, i_action_ok};
        end
    end

    iss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Core updates sequencer state on the same edge that loads the result register,
    // so the next word in the input register already sees the new phase.
    iss_seq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_event  (r_event),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // Result register: one strobe per word, no backpressure.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result <= core_result;
        end
    end

    assign o_busy      = r_busy;
    assign o_valid     = r_out_valid;
    assign o_action    = r_result.action;
    assign o_move_mm   = r_result.move_mm;
    assign o_sort_slot = r_result.slot;
    assign o_sort_good = r_result.good;
    assign o_accepted  = r_result.accepted;
    assign o_phase     = r_result.phase;

    // Every accepted word yields exactly one result once it has passed the input and result registers.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> ##1 o_valid)
        else $error("accepted word produced no result strobe");

    // A sort action always leaves the sequencer in the sorting phase.
    a_sort_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action == ACT_SORT) |-> (o_phase == PH_SORTING))
        else $error("sort action outside sorting phase");

    // An accepted verdict leaves the sequencer inspecting or heading to the sort area.
    a_accept_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (o_phase == PH_INSPECT || o_phase == PH_TO_SORT))
        else $error("verdict accepted in wrong phase");

    // Tray moves always carry a nonzero distance; other actions carry none.
    a_move_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_action == ACT_FWD || o_action == ACT_BACK) == (o_move_mm != '0)))
        else $error("move distance inconsistent with action");

endmodule

`default_nettype wire
